FILE: design/secded_72_64_codec_unit_assert.svh
// Assertion macros for the SEC-DED codec. They use the block clock and reset.
`ifndef SECDED_72_64_CODEC_UNIT_ASSERT_SVH
`define SECDED_72_64_CODEC_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SDC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdc assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdc assertion failed");

`endif

FILE: design/sdc_pkg.sv
package sdc_pkg;

  localparam int unsigned DATA_BITS  = 64;
  localparam int unsigned CHECK_BITS = 8;
  localparam int unsigned IDX_BITS   = $clog2(DATA_BITS);

  typedef logic [DATA_BITS-1:0]  data_t;
  typedef logic [CHECK_BITS-1:0] check_t;

  // Command codes.
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_CORRECTED = 2'd1;
  localparam status_t STATUS_UNCORR    = 2'd2;

  // Rows of the parity matrix; the top byte of each row covers data bits 63..56.
  localparam data_t P_ROWS [CHECK_BITS] = '{
    64'hFF0F0F0C68888880,
    64'hF0FF00F364444440,
    64'h30F0FF0F02222226,
    64'hCF00F0FF01111116,
    64'h68888880FF0F00F3,
    64'h64444440F0FF0F0C,
    64'h02222226CF00FF0F,
    64'h0111111630F0F0FF
  };

  // Request and response payloads.
  typedef struct packed {
    logic   cmd;
    data_t  data_in;
    check_t check_in;
  } req_t;

  typedef struct packed {
    data_t   data_out;
    check_t  check_out;
    check_t  syndrome_out;
    status_t status;
  } rsp_t;

  // Syndrome that a single error in data bit b produces.
  function automatic check_t data_column(input logic [IDX_BITS-1:0] b);
    check_t c;
    for (int i = 0; i < CHECK_BITS; i++) begin
      c[i] = P_ROWS[i][b];
    end
    return c;
  endfunction

endpackage

FILE: design/sdc_in_if.sv
// Request channel into the codec.
interface sdc_in_if;
  import sdc_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/sdc_out_if.sv
// Response channel out of the codec.
interface sdc_out_if;
  import sdc_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/secded_72_64_codec_unit.sv
// Path: an accepted request is registered in stage 1, in stage 2, then in rsp_q.
// Throughput: one request per cycle when out_o.ready is high; the three stages
// advance independently, so a bubble fills while the response register stalls.
// Stages: check-byte parity, syndrome column match, priority select and fix.
// Reset: rst_ni clears all stage valid bits asynchronously; data needs none.
`include "secded_72_64_codec_unit_assert.svh"

module secded_72_64_codec_unit (
  input logic       clk_i,
  input logic       rst_ni,
  sdc_in_if.sink    in_i,
  sdc_out_if.source out_o
);
  import sdc_pkg::*;

  // Stage enables: a stage loads when it is empty or its contents move on.
  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // Stage 1: recompute the check byte from the incoming data.
  check_t calc_d;
  logic   cmd1_q;
  data_t  data1_q;
  check_t rx1_q, calc1_q;

  sdc_check_gen u_check_gen (
    .data_i  (in_i.payload.data_in),
    .check_o (calc_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      cmd1_q  <= in_i.payload.cmd;
      data1_q <= in_i.payload.data_in;
      rx1_q   <= in_i.payload.check_in;
      calc1_q <= calc_d;
    end
  end

  // Stage 2: form the syndrome and compare it against every column.
  check_t syn_d;
  check_t chkm_d;
  data_t  datam_d;
  check_t syn2_q, chkm2_q, chk2_q;
  data_t  datam2_q, data2_q;

  assign syn_d = (cmd1_q == CMD_DECODE) ? (calc1_q ^ rx1_q) : '0;

  always_comb begin
    for (int k = 0; k < CHECK_BITS; k++) begin
      chkm_d[k] = (syn_d == (check_t'(1) << k));
    end
  end

  for (genvar b = 0; b < DATA_BITS; b++) begin : g_col
    assign datam_d[b] = (syn_d != '0) && (syn_d == data_column(IDX_BITS'(b)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      syn2_q   <= syn_d;
      chkm2_q  <= chkm_d;
      datam2_q <= datam_d;
      data2_q  <= data1_q;
      chk2_q   <= (cmd1_q == CMD_DECODE) ? rx1_q : calc1_q;
    end
  end

  // Stage 3: check-bit matches win, then the lowest matching data bit.
  logic    found_chk, found;
  data_t   flip;
  status_t status_d;
  rsp_t    rsp_q;

  assign found_chk = |chkm2_q;
  assign flip      = found_chk ? '0 : (datam2_q & (~datam2_q + data_t'(1)));
  assign found     = found_chk || (|datam2_q);

  always_comb begin
    if (syn2_q == '0) begin
      status_d = STATUS_OK;
    end else if (found) begin
      status_d = STATUS_CORRECTED;
    end else begin
      status_d = STATUS_UNCORR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      rsp_q.data_out     <= data2_q ^ flip;
      rsp_q.check_out    <= chk2_q ^ chkm2_q;
      rsp_q.syndrome_out <= syn2_q;
      rsp_q.status       <= status_d;
    end
  end

  assign out_o.valid   = v3_q;
  assign out_o.payload = rsp_q;

  // An uncorrectable syndrome passes the stored word through untouched.
  `SDC_ASSERT_NEXT(a_uncorr_passthru, v2_q && en3 && syn2_q != '0 && !found, rsp_q.data_out == $past(data2_q) && rsp_q.status == STATUS_UNCORR)
  // A stalled first stage keeps its request.
  `SDC_ASSERT_NEXT(a_s1_hold, v1_q && !en2, v1_q && $stable(data1_q))
  // At most one data bit is ever flipped, and never alongside a check-bit fix.
  `SDC_ASSERT_SAME(a_single_flip, v2_q, $onehot0(flip) && !(found_chk && (|flip)))

endmodule

FILE: design/sdc_check_gen.sv
module sdc_check_gen (
  input  sdc_pkg::data_t  data_i,
  output sdc_pkg::check_t check_o
);
  import sdc_pkg::*;

  // Each check bit is the even parity of the data under one matrix row.
  always_comb begin
    for (int i = 0; i < CHECK_BITS; i++) begin
      check_o[i] = ^(data_i & P_ROWS[i]);
    end
  end

endmodule

FILE: tb/sv/tb_secded_72_64_codec_unit.sv
module tb_secded_72_64_codec_unit;
  import sdc_pkg::*;

  // Expected results of the codec, kept in request order.
  class codeword_ledger;
    // Parity matrix rows; the top byte of a row covers data bits 63..56.
    logic [63:0] parity_rows [8] = '{
      64'hFF0F0F0C68888880,
      64'hF0FF00F364444440,
      64'h30F0FF0F02222226,
      64'hCF00F0FF01111116,
      64'h68888880FF0F00F3,
      64'h64444440F0FF0F0C,
      64'h02222226CF00FF0F,
      64'h0111111630F0F0FF
    };
    rsp_t awaited_words [$];
    int unsigned error_count = 0;

    // Check bit i is the even parity of the data masked by row i.
    function check_t check_byte(data_t word);
      check_t c;
      for (int i = 0; i < CHECK_BITS; i++) begin
        c[i] = ^(word & parity_rows[i]);
      end
      return c;
    endfunction

    // Encode, or decode with single-error correction.
    function rsp_t secded_result(req_t r);
      rsp_t res;
      check_t col;
      bit found;
      res.data_out     = r.data_in;
      res.check_out    = check_byte(r.data_in);
      res.syndrome_out = '0;
      res.status       = STATUS_OK;
      found            = 1'b0;
      if (r.cmd == CMD_DECODE) begin
        res.syndrome_out = res.check_out ^ r.check_in;
        res.check_out    = r.check_in;
        if (res.syndrome_out != '0) begin
          // A check-bit column is a single set bit and takes priority.
          if ($onehot(res.syndrome_out)) begin
            res.check_out = r.check_in ^ res.syndrome_out;
            found         = 1'b1;
          end
          for (int b = 0; b < DATA_BITS && !found; b++) begin
            for (int i = 0; i < CHECK_BITS; i++) begin
              col[i] = parity_rows[i][b];
            end
            if (col == res.syndrome_out) begin
              res.data_out[b] = ~res.data_out[b];
              found           = 1'b1;
            end
          end
          res.status = found ? STATUS_CORRECTED : STATUS_UNCORR;
        end
      end
      return res;
    endfunction

    function void note_failure(string msg);
      error_count++;
      if (error_count <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void log_request(req_t r);
      awaited_words.push_back(secded_result(r));
    endfunction

    function void compare_response(rsp_t got);
      rsp_t want;
      if (awaited_words.size() == 0) begin
        note_failure($sformatf("unexpected response: data %h check %h syndrome %h status %0d",
                               got.data_out, got.check_out, got.syndrome_out, got.status));
        return;
      end
      want = awaited_words.pop_front();
      if (got.data_out !== want.data_out || got.check_out !== want.check_out ||
          got.syndrome_out !== want.syndrome_out || got.status !== want.status) begin
        note_failure($sformatf({"mismatch: data %h/%h check %h/%h syndrome %h/%h",
                                " status %0d/%0d (expected/actual)"},
                               want.data_out, got.data_out, want.check_out, got.check_out,
                               want.syndrome_out, got.syndrome_out, want.status, got.status));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 67;
  codeword_ledger board = new;

  sdc_in_if in_ch ();
  sdc_out_if out_ch ();

  secded_72_64_codec_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // Decode request carrying a codeword with the correct check byte.
  function automatic req_t clean_word(data_t w);
    req_t r;
    r.cmd      = CMD_DECODE;
    r.data_in  = w;
    r.check_in = board.check_byte(w);
    return r;
  endfunction

  // Flip codeword bit k: bits 0..7 are the check byte, 8..71 the data word.
  function automatic req_t flip_bit(req_t r, int unsigned k);
    logic [71:0] cw;
    cw         = {r.data_in, r.check_in} ^ (72'd1 << k);
    r.data_in  = cw[71:8];
    r.check_in = cw[7:0];
    return r;
  endfunction

  // Encodes, clean words, one or two bit errors, or a random check byte.
  function automatic req_t random_request();
    req_t r;
    data_t w;
    int unsigned pick;
    int unsigned a;
    int unsigned b;
    pick = $urandom_range(99);
    if (pick < 6) begin
      w = '0;
    end else if (pick < 12) begin
      w = '1;
    end else begin
      w = {$urandom, $urandom};
    end
    a = $urandom_range(71);
    b = $urandom_range(70);
    if (b >= a) begin
      b++;
    end
    pick = $urandom_range(99);
    if (pick < 20) begin
      r.cmd      = CMD_ENCODE;
      r.data_in  = w;
      r.check_in = check_t'($urandom);
    end else if (pick < 35) begin
      r = clean_word(w);
    end else if (pick < 65) begin
      r = flip_bit(clean_word(w), a);
    end else if (pick < 75) begin
      r = flip_bit(clean_word(w), a % CHECK_BITS);
    end else if (pick < 90) begin
      r = flip_bit(flip_bit(clean_word(w), a), b);
    end else begin
      r          = clean_word(w);
      r.check_in = check_t'($urandom);
    end
    return r;
  endfunction

  // Present one request, with random idle cycles ahead of it.
  task automatic push_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= r;
    do begin
      @(posedge clk_i);
    end while (in_ch.ready !== 1'b1);
    board.log_request(r);
  endtask

  // Request side: directed cases, then three random phases of varied stalls.
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_request(req_t'{CMD_ENCODE, 64'h0, 8'h00});
    push_request(req_t'{CMD_ENCODE, 64'hFFFFFFFFFFFFFFFF, 8'hFF});
    push_request(req_t'{CMD_ENCODE, 64'h0000000000000001, 8'h00});
    push_request(req_t'{CMD_ENCODE, 64'h8000000000000000, 8'hFF});
    push_request(req_t'{CMD_ENCODE, 64'hAAAAAAAAAAAAAAAA, 8'h55});
    push_request(clean_word(64'h0));
    push_request(clean_word(64'hFFFFFFFFFFFFFFFF));
    push_request(clean_word(64'h0123456789ABCDEF));
    // Single data-bit errors at both ends of the word.
    push_request(flip_bit(clean_word(64'h0123456789ABCDEF), 8));
    push_request(flip_bit(clean_word(64'hFFFFFFFFFFFFFFFF), 71));
    // Single check-bit errors at both ends of the check byte.
    push_request(flip_bit(clean_word(64'h5555555555555555), 0));
    push_request(flip_bit(clean_word(64'h0), 7));
    // Double errors are flagged and leave the word alone.
    push_request(flip_bit(flip_bit(clean_word(64'hFEDCBA9876543210), 8), 9));
    push_request(flip_bit(flip_bit(clean_word(64'h0F0F0F0F0F0F0F0F), 13), 2));
    push_request(flip_bit(flip_bit(clean_word(64'h0), 0), 7));
    push_request(req_t'{CMD_DECODE, 64'h0, 8'hFF});
    push_request(req_t'{CMD_DECODE, 64'hFFFFFFFFFFFFFFFF, 8'h00});

    repeat (270) push_request(random_request());
    send_idle_pct = 67;
    recv_idle_pct = 28;
    repeat (280) push_request(random_request());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (283) push_request(random_request());
    in_ch.valid <= 1'b0;

    // Drain the pipeline, then keep watching for stray responses.
    while (board.awaited_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (board.awaited_words.size() != 0) begin
      board.note_failure("responses still awaited at end of run");
    end
    if (board.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Response side: sample at the edge, then pick the next ready value.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        board.compare_response(out_ch.payload);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/sdc_pkg.sv
design/sdc_in_if.sv
design/sdc_out_if.sv
design/sdc_check_gen.sv
design/secded_72_64_codec_unit.sv
tb/sv/tb_secded_72_64_codec_unit.sv
